>>> hw/rtl/ole_pkg.sv
// Shared constants, operation and status codes, and the cell control type
// for the ordered list engine. No dependencies.
package ole_pkg;

  localparam int LIST_DEPTH = 32;

  localparam int OP_W   = 3;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;
  localparam int FPOS_W = 5;
  localparam int LEN_W  = 6;

  localparam int IDX_W  = $clog2(LIST_DEPTH);
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int FPX_W  = (IDX_W > FPOS_W) ? IDX_W : FPOS_W;
  localparam int LENX_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
  localparam logic [OP_W-1:0] OP_FIND      = 3'd6;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic load_new;
    logic take_left;
    logic take_right;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/ole_if.sv
// Valid/ready channel interfaces for the ordered list engine: one for
// operation requests, one for results. Depends on ole_pkg.
interface ole_in_if;
  logic                             valid;
  logic                             ready;
  logic [ole_pkg::OP_W-1:0]         operation;
  logic [ole_pkg::POS_W-1:0]        position;
  logic signed [ole_pkg::VAL_W-1:0] item_value;

  modport source (output valid, operation, position, item_value, input ready);
  modport sink   (input valid, operation, position, item_value, output ready);
endinterface

interface ole_out_if;
  logic                       valid;
  logic                       ready;
  logic [ole_pkg::ST_W-1:0]   status;
  logic                       found;
  logic [ole_pkg::FPOS_W-1:0] found_position;
  logic [ole_pkg::LEN_W-1:0]  length;

  modport source (output valid, status, found, found_position, length, input ready);
  modport sink   (input valid, status, found, found_position, length, output ready);
endinterface

>>> hw/rtl/ole_cell.sv
// One storage cell of the list chain: holds one entry, takes a neighbour's
// entry or a new value, and compares its entry. Depends on ole_pkg.
module ole_cell (
  input  logic                             clk,
  input  ole_pkg::cell_ctrl_t              ctrl,
  input  logic signed [ole_pkg::VAL_W-1:0] new_value,
  input  logic signed [ole_pkg::VAL_W-1:0] left_value,
  input  logic signed [ole_pkg::VAL_W-1:0] right_value,
  output logic signed [ole_pkg::VAL_W-1:0] value,
  output logic                             match
);

  logic signed [ole_pkg::VAL_W-1:0] value_r;

  // The control bits never overlap; with none of them set the entry is held.
  always_ff @(posedge clk) begin
    if (ctrl.load_new) begin
      value_r <= new_value;
    end else if (ctrl.take_left) begin
      value_r <= left_value;
    end else if (ctrl.take_right) begin
      value_r <= right_value;
    end
  end

  assign value = value_r;
  assign match = (value_r == new_value);

endmodule

>>> hw/rtl/ole_first_match.sv
// Two-stage registered search for the lowest set bit of the match vector,
// giving a found flag and its index. Depends on ole_pkg.
module ole_first_match (
  input  logic                        clk,
  input  logic [ole_pkg::LIST_DEPTH-1:0] match_vec,
  output logic                        found,
  output logic [ole_pkg::IDX_W-1:0]   index
);

  logic [ole_pkg::LIST_DEPTH-1:0] match_r;
  logic [ole_pkg::LIST_DEPTH-1:0] lowbit_r;

  always_ff @(posedge clk) begin
    match_r  <= match_vec;
    lowbit_r <= match_r & (~match_r + ole_pkg::LIST_DEPTH'(1));
  end

  // The isolated bit is one-hot, so the index is an OR of the bit positions.
  always_comb begin
    index = '0;
    for (int j = 0; j < ole_pkg::LIST_DEPTH; j++) begin
      if (lowbit_r[j]) begin
        index = index | ole_pkg::IDX_W'(j);
      end
    end
  end

  assign found = |lowbit_r;

endmodule

>>> hw/rtl/ordered_list_engine.sv
// Ordered list engine top level: a chain of LIST_DEPTH cells holding the list.
// An insert or delete gives its result through the result register; a find also
// passes the match and low-bit registers of the search. Throughput: one insert or
// delete per cycle while results are taken; a find holds the input during the search.
// Reset (rst_n, synchronous, active low) empties the list and the result
// register; the cell contents are left as they are. Depends on ole_pkg, ole_if.
module ordered_list_engine (
  input  logic         clk,
  input  logic         rst_n,
  ole_in_if.sink       in_ch,
  ole_out_if.source    out_ch
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SRCH1 = 2'd1;
  localparam logic [1:0] S_SRCH2 = 2'd2;

  localparam int N = ole_pkg::LIST_DEPTH;

  logic [1:0]                    state_r, state_nxt;
  logic [ole_pkg::CNT_W-1:0]     count_r, count_nxt;

  logic                          out_valid_r;
  logic [ole_pkg::ST_W-1:0]      out_status_r;
  logic                          out_found_r;
  logic [ole_pkg::FPOS_W-1:0]    out_fpos_r;
  logic [ole_pkg::LEN_W-1:0]     out_len_r;

  logic                          accept;
  logic                          is_ins, is_del, is_find, op_ok;
  logic [ole_pkg::ST_W-1:0]      status_c;
  logic [ole_pkg::CMP_W-1:0]     cnt_ext, pos_ext, pos_eff;

  logic signed [ole_pkg::VAL_W-1:0] cell_val [N];
  logic [N-1:0]                  cell_match;
  logic [N-1:0]                  match_vec;
  ole_pkg::cell_ctrl_t           cell_ctrl [N];

  logic                          srch_found;
  logic [ole_pkg::IDX_W-1:0]     srch_index;
  logic [ole_pkg::FPX_W-1:0]     fpos_ext;
  logic [ole_pkg::LENX_W-1:0]    len_ext;

  // A new transaction is taken only when no find is in flight and the result
  // register is free, or is being emptied in this very cycle.
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  assign cnt_ext = ole_pkg::CMP_W'(count_r);
  assign pos_ext = ole_pkg::CMP_W'(in_ch.position);

  // Decode the operation into an effective position and a status. A refused
  // operation leaves op_ok low, so no cell moves and the count stays.
  always_comb begin
    is_ins   = 1'b0;
    is_del   = 1'b0;
    is_find  = 1'b0;
    pos_eff  = '0;
    unique case (in_ch.operation)
      ole_pkg::OP_INS_FRONT: begin
        is_ins  = 1'b1;
        pos_eff = '0;
      end
      ole_pkg::OP_INS_BACK: begin
        is_ins  = 1'b1;
        pos_eff = cnt_ext;
      end
      ole_pkg::OP_INS_AT: begin
        is_ins  = 1'b1;
        pos_eff = pos_ext;
      end
      ole_pkg::OP_DEL_FRONT: begin
        is_del  = 1'b1;
        pos_eff = '0;
      end
      ole_pkg::OP_DEL_BACK: begin
        is_del  = 1'b1;
        pos_eff = cnt_ext - ole_pkg::CMP_W'(1);
      end
      ole_pkg::OP_DEL_AT: begin
        is_del  = 1'b1;
        pos_eff = pos_ext;
      end
      ole_pkg::OP_FIND: begin
        is_find = 1'b1;
      end
      default: begin
      end
    endcase

    status_c = ole_pkg::ST_OK;
    if (is_ins) begin
      // The range check is made before the full check.
      priority if (pos_eff > cnt_ext) begin
        status_c = ole_pkg::ST_RANGE;
      end else if (cnt_ext >= ole_pkg::CMP_W'(N)) begin
        status_c = ole_pkg::ST_FULL;
      end else begin
        status_c = ole_pkg::ST_OK;
      end
    end else if (is_del) begin
      priority if (count_r == '0) begin
        status_c = ole_pkg::ST_EMPTY;
      end else if (pos_eff >= cnt_ext) begin
        status_c = ole_pkg::ST_RANGE;
      end else begin
        status_c = ole_pkg::ST_OK;
      end
    end
    op_ok = (status_c == ole_pkg::ST_OK);

    count_nxt = count_r;
    if (accept && op_ok && is_ins) begin
      count_nxt = count_r + ole_pkg::CNT_W'(1);
    end else if (accept && op_ok && is_del) begin
      count_nxt = count_r - ole_pkg::CNT_W'(1);
    end
  end

  // The cell chain. An insert moves every cell past the position one step
  // towards the tail and loads the new value at the position; a delete pulls
  // every cell from the position onwards one step towards the head. The last
  // cell's right-hand neighbour is unused: after a delete it lies past the end.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [ole_pkg::VAL_W-1:0] left_v, right_v;

    if (i == 0) begin : g_head
      assign left_v = in_ch.item_value;
    end else begin : g_body
      assign left_v = cell_val[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_v = in_ch.item_value;
    end else begin : g_mid
      assign right_v = cell_val[i+1];
    end

    assign cell_ctrl[i].load_new   = accept && op_ok && is_ins &&
                                     (ole_pkg::CMP_W'(i) == pos_eff);
    assign cell_ctrl[i].take_left  = accept && op_ok && is_ins &&
                                     (ole_pkg::CMP_W'(i) > pos_eff);
    assign cell_ctrl[i].take_right = accept && op_ok && is_del &&
                                     (ole_pkg::CMP_W'(i) >= pos_eff);

    // Only cells below the count hold list entries.
    assign match_vec[i] = cell_match[i] && (ole_pkg::CMP_W'(i) < cnt_ext);

    ole_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl[i]),
      .new_value   (in_ch.item_value),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_val[i]),
      .match       (cell_match[i])
    );
  end

  // The match vector is captured on the accepting edge; the search result is
  // ready in state S_SRCH2, while no transaction can change the cells.
  ole_first_match u_search (
    .clk       (clk),
    .match_vec (match_vec),
    .found     (srch_found),
    .index     (srch_index)
  );

  assign fpos_ext = ole_pkg::FPX_W'(srch_index);
  assign len_ext  = ole_pkg::LENX_W'(count_nxt);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && is_find) state_nxt = S_SRCH1;
      S_SRCH1: state_nxt = S_SRCH2;
      S_SRCH2: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if ((accept && !is_find) || (state_r == S_SRCH2)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: immediate for list updates, from the search for a find.
  always_ff @(posedge clk) begin
    if (accept && !is_find) begin
      out_status_r <= status_c;
      out_found_r  <= 1'b0;
      out_fpos_r   <= '0;
      out_len_r    <= len_ext[ole_pkg::LEN_W-1:0];
    end else if (state_r == S_SRCH2) begin
      out_status_r <= ole_pkg::ST_OK;
      out_found_r  <= srch_found;
      out_fpos_r   <= srch_found ? fpos_ext[ole_pkg::FPOS_W-1:0] : '0;
      out_len_r    <= len_ext[ole_pkg::LEN_W-1:0];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.found_position = out_fpos_r;
  assign out_ch.length         = out_len_r;

endmodule

>>> hw/rtl/ole_checker.sv
// Port-level checks for the ordered list engine, bound to the top level.
// Depends on ole_pkg and on the top level's channel ports.
module ole_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ole_pkg::ST_W-1:0]   out_status,
  input logic                       out_found,
  input logic [ole_pkg::FPOS_W-1:0] out_fpos,
  input logic [ole_pkg::LEN_W-1:0]  out_length
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_found) && $stable(out_fpos) && $stable(out_length))
    else $error("stalled result changed");

  a_no_take_when_stalled: assert property (@(posedge clk)
    out_valid && !out_ready |-> !in_ready)
    else $error("transaction taken while result is stalled");

  a_found_ok: assert property (@(posedge clk)
    out_valid && out_found |-> out_status == ole_pkg::ST_OK)
    else $error("found flag with a failure status");

  a_fpos_zero: assert property (@(posedge clk)
    out_valid && !out_found |-> out_fpos == '0)
    else $error("position given without a match");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ordered_list_engine ole_checker u_ole_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_found  (out_ch.found),
  .out_fpos   (out_ch.found_position),
  .out_length (out_ch.length)
);

>>> sim/ole_list_checker.sv
// Result checker for the ordered list engine: it keeps a copy of the list, works out
// the result of each request and compares it with what comes out.
// Depends on ole_pkg and the channel interfaces in ole_if.
module ole_list_checker
  import ole_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ole_in_if    in_ch,
  ole_out_if   out_ch,
  output int   mismatch_count,
  output int   results_awaited
);

  localparam int MAX_REPORTED = 60;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic              found;
    logic [FPOS_W-1:0] found_position;
    logic [LEN_W-1:0]  length;
  } list_result_t;

  logic signed [VAL_W-1:0] shadow_list[$];
  list_result_t            awaited_results[$];
  int                      mismatches = 0;
  int                      results_seen = 0;

  assign mismatch_count = mismatches;

  // Applies one request to the shadow list and returns the result it should produce.
  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic signed [VAL_W-1:0] val);
    list_result_t res;
    int           at;
    int           idx;
    res = '0;
    at  = 0;
    case (op)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        if (op == OP_INS_BACK) at = shadow_list.size();
        else if (op == OP_INS_AT) at = int'(pos);
        // The position check takes precedence over the full check.
        if (at > shadow_list.size()) res.status = ST_RANGE;
        else if (shadow_list.size() >= LIST_DEPTH) res.status = ST_FULL;
        else shadow_list.insert(at, val);
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
        if (op == OP_DEL_BACK) at = shadow_list.size() - 1;
        else if (op == OP_DEL_AT) at = int'(pos);
        if (shadow_list.size() == 0) res.status = ST_EMPTY;
        else if (at >= shadow_list.size()) res.status = ST_RANGE;
        else shadow_list.delete(at);
      end
      OP_FIND: begin
        for (idx = 0; idx < shadow_list.size(); idx++) begin
          if (!res.found && shadow_list[idx] == val) begin
            res.found          = 1'b1;
            res.found_position = FPOS_W'(idx);
          end
        end
      end
      default: begin
      end
    endcase
    res.length = LEN_W'(shadow_list.size());
    return res;
  endfunction

  // Prints one line per mismatch, up to a cap so that a broken design cannot flood
  // the log, and counts every one of them.
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTED)
      $display("[%0t] result %0d: %s is %0d, expected %0d", $realtime, results_seen,
               what, got, want);
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      shadow_list.delete();
      awaited_results.delete();
    end else begin
      // The request is taken first; a result at the same edge belongs to an older one.
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        awaited_results.push_back(apply_list_op(in_ch.operation, in_ch.position,
                                                in_ch.item_value));
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unrequested result, length", 8'(out_ch.length), 8'd0);
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", 8'(out_ch.status), 8'(want.status));
          if (out_ch.found !== want.found)
            report_mismatch("found", 8'(out_ch.found), 8'(want.found));
          if (out_ch.found_position !== want.found_position)
            report_mismatch("found_position", 8'(out_ch.found_position),
                            8'(want.found_position));
          if (out_ch.length !== want.length)
            report_mismatch("length", 8'(out_ch.length), 8'(want.length));
        end
        results_seen++;
      end
    end
    results_awaited <= awaited_results.size();
  end

endmodule

>>> sim/tb_top.sv
// Testbench top for the ordered list engine: clock, reset, request stimulus and
// result back-pressure, with the verdict taken from ole_list_checker.
// Depends on ole_pkg, ole_if, ordered_list_engine and ole_list_checker.
module tb_top;
  import ole_pkg::*;

  // Operation code seven is unused by the engine; it must leave the list alone.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  localparam int TOTAL_ITEMS     = 1650;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_AT     = 400;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_CYCLES    = 8;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // The phases of the random part. Growing phases fill the list up to its depth,
  // shrinking phases empty it again, and mixed phases wander in between.
  typedef enum logic [1:0] {PH_GROW, PH_SHRINK, PH_MIX} phase_t;

  logic clk;
  logic rst_n;
  int   items_sent = 0;
  int   cycle_count = 0;
  int   mismatch_count;
  int   results_awaited;

  logic signed [VAL_W-1:0] value_pool[8];

  ole_in_if  in_ch();
  ole_out_if out_ch();

  ordered_list_engine uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ole_list_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatch_count  (mismatch_count),
    .results_awaited (results_awaited)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gaps between transactions: mostly none or short, occasionally long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Half of the values come from a small pool, so that finds hit and duplicates occur;
  // the rest are extremes or fully random words.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return value_pool[$urandom_range(0, 7)];
    if (roll < 56) return VAL_MIN;
    if (roll < 62) return VAL_MAX;
    return $urandom;
  endfunction

  // Positions cluster around the lengths that the list actually reaches, with some
  // reaching the top of the field to exercise the range checks.
  function automatic logic [POS_W-1:0] pick_position();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return POS_W'($urandom_range(0, 3));
    if (roll < 90) return POS_W'($urandom_range(0, LIST_DEPTH + 1));
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  // The operation mix depends on the phase; each row of thresholds is cumulative.
  function automatic logic [OP_W-1:0] pick_operation(input phase_t phase);
    int roll;
    roll = $urandom_range(0, 99);
    case (phase)
      PH_GROW: begin
        if (roll < 25) return OP_INS_FRONT;
        if (roll < 45) return OP_INS_BACK;
        if (roll < 70) return OP_INS_AT;
        if (roll < 76) return OP_DEL_FRONT;
        if (roll < 81) return OP_DEL_BACK;
        if (roll < 86) return OP_DEL_AT;
        if (roll < 98) return OP_FIND;
        return OP_UNUSED;
      end
      PH_SHRINK: begin
        if (roll < 7)  return OP_INS_FRONT;
        if (roll < 13) return OP_INS_BACK;
        if (roll < 20) return OP_INS_AT;
        if (roll < 40) return OP_DEL_FRONT;
        if (roll < 58) return OP_DEL_BACK;
        if (roll < 80) return OP_DEL_AT;
        if (roll < 98) return OP_FIND;
        return OP_UNUSED;
      end
      default: begin
        if (roll < 12) return OP_INS_FRONT;
        if (roll < 24) return OP_INS_BACK;
        if (roll < 38) return OP_INS_AT;
        if (roll < 50) return OP_DEL_FRONT;
        if (roll < 60) return OP_DEL_BACK;
        if (roll < 72) return OP_DEL_AT;
        if (roll < 97) return OP_FIND;
        return OP_UNUSED;
      end
    endcase
  endfunction

  // Offers one request and holds it until the engine takes the transaction. Valid
  // is only lowered when a gap follows, so back-to-back requests keep it high.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [VAL_W-1:0] val, input bit no_gaps);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.position   <= pos;
    in_ch.item_value <= val;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    items_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The result side. Once, after a few hundred requests, it refuses results for a
  // long stretch so that the engine backs up and stalls its input; otherwise it
  // alternates between runs of readiness and stalls of random length.
  initial begin
    int  roll;
    bit  held_off;
    held_off = 1'b0;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held_off && items_sent >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else if (roll < 63) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(50, 150)) @(posedge clk);
      end else if (roll < 94) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  // Watchdog: a run that has not finished well inside this many cycles has hung.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ordered_list_engine test failed");
    $finish;
  end

  initial begin
    phase_t phase;
    int     phase_items;
    bit     no_gaps;
    int     k;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= OP_INS_FRONT;
    in_ch.position   <= '0;
    in_ch.item_value <= '0;

    value_pool[0] = 32'sd0;
    value_pool[1] = -32'sd1;
    value_pool[2] = VAL_MIN;
    value_pool[3] = VAL_MAX;
    for (k = 4; k < 8; k++) value_pool[k] = $urandom;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Every delete on the empty list must report it empty, and a find
    // there must come back without a match.
    send_request(OP_DEL_FRONT, 6'd0, 32'sd0, 1'b0);
    send_request(OP_DEL_BACK, 6'd0, 32'sd0, 1'b0);
    send_request(OP_DEL_AT, 6'd0, 32'sd0, 1'b0);
    send_request(OP_FIND, 6'd0, 32'sd0, 1'b0);
    send_request(OP_UNUSED, 6'd5, 32'sd7, 1'b0);
    // Inserting beyond the length is out of range, even on an empty list.
    send_request(OP_INS_AT, 6'd1, 32'sd9, 1'b0);
    send_request(OP_INS_AT, 6'd0, 32'sd0, 1'b0);
    send_request(OP_INS_FRONT, 6'd0, VAL_MIN, 1'b0);
    send_request(OP_INS_BACK, 6'd0, VAL_MAX, 1'b0);
    // Inserting at the position equal to the length appends at the back.
    send_request(OP_INS_AT, 6'd3, -32'sd1, 1'b0);
    send_request(OP_INS_AT, 6'd63, 32'sd4, 1'b0);
    send_request(OP_INS_AT, 6'd2, 32'sh5555_5555, 1'b0);
    send_request(OP_INS_BACK, 6'd0, 32'sd0, 1'b0);
    // A value held twice must be found at its first position.
    send_request(OP_FIND, 6'd0, 32'sd0, 1'b0);
    send_request(OP_FIND, 6'd63, VAL_MAX, 1'b0);
    send_request(OP_FIND, 6'd0, 32'sh1234_5678, 1'b0);
    // Deleting at the length, or far beyond it, is out of range.
    send_request(OP_DEL_AT, 6'd6, 32'sd0, 1'b0);
    send_request(OP_DEL_AT, 6'd63, 32'sd0, 1'b0);
    send_request(OP_DEL_AT, 6'd2, 32'sd0, 1'b0);
    send_request(OP_DEL_BACK, 6'd0, 32'sd0, 1'b0);
    send_request(OP_DEL_FRONT, 6'd0, 32'sd0, 1'b0);
    send_request(OP_FIND, 6'd0, VAL_MIN, 1'b0);
    send_request(OP_INS_AT, 6'd1, 32'shAAAA_AAAA, 1'b0);

    // Random part, in phases. The first phase always grows, so that the list is
    // filled to its depth and the full case is met early.
    phase = PH_GROW;
    while (items_sent < TOTAL_ITEMS) begin
      phase_items = $urandom_range(40, 110);
      no_gaps     = ($urandom_range(0, 99) < 20);
      for (k = 0; k < phase_items; k++)
        send_request(pick_operation(phase), pick_position(), pick_value(), no_gaps);
      case ($urandom_range(0, 2))
        0:       phase = PH_GROW;
        1:       phase = PH_SHRINK;
        default: phase = PH_MIX;
      endcase
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for the checker to see every result, then DRAIN_CYCLES more in
    // case anything unrequested follows.
    @(posedge clk);
    while (results_awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && results_awaited == 0)
      $display("ordered_list_engine test passed");
    else
      $display("ordered_list_engine test failed");
    $finish;
  end

endmodule
